[sv/cdg_pkg.sv]
// Package for the CD+G packet renderer: payload structs, instruction codes,
// screen constants and the front-to-back command type. No dependencies.
package cdg_pkg;

    localparam int unsigned ScreenHeight = 216;
    localparam int unsigned ScreenWidth  = 300;
    localparam int unsigned FrameDepth   = ScreenHeight * ScreenWidth;
    localparam int unsigned AddrW        = $clog2(FrameDepth);

    localparam logic [5:0] CmdGraphics   = 6'd9;
    localparam logic [5:0] InstrPreset   = 6'd1;
    localparam logic [5:0] InstrBorder   = 6'd2;
    localparam logic [5:0] InstrTile     = 6'd6;
    localparam logic [5:0] InstrXorTile  = 6'd38;
    localparam logic [5:0] InstrPalLow   = 6'd30;
    localparam logic [5:0] InstrPalHigh  = 6'd31;

    localparam logic [7:0] BorderRows    = 8'd12;
    localparam logic [7:0] BorderRowEnd  = 8'd204;
    localparam logic [8:0] BorderCols    = 9'd6;
    localparam logic [8:0] BorderColEnd  = 9'd294;

    typedef struct packed {
        logic        func;
        logic [5:0]  command;
        logic [5:0]  instruction;
        logic [47:0] data_low;
        logic [47:0] data_high;
        logic [7:0]  read_row;
        logic [8:0]  read_col;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  pixel_index;
        logic [11:0] pixel_color;
        logic        handled;
        logic        palette_updated;
        logic        refresh;
    } t_out_item;

    // Operation the back end carries out.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_FILL,
        OP_BORDER,
        OP_TILE,
        OP_XOR_TILE,
        OP_PALETTE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [95:0] data;
        logic [7:0]  row;
        logic [8:0]  col;
        logic        handled;
        logic        pal_upd;
        logic        refresh;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW_READ,
        ST_RMW_WRITE,
        ST_SWEEP,
        ST_READ_WAIT,
        ST_RESULT
    } t_state;

endpackage

[sv/cdg_front.sv]
// Front end of the CD+G renderer: accepts transactions, classifies them and
// hands commands to a two-entry queue. Depends on cdg_pkg.
module cdg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cdg_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output cdg_pkg::t_cmd     o_cmd
);

    cdg_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    cdg_pkg::t_cmd n_cmd;
    logic          push, pop;

    // Decode one transaction into a back-end command.
    always_comb begin
        n_cmd         = '0;
        n_cmd.op      = cdg_pkg::OP_NONE;
        n_cmd.data    = {i_item.data_high, i_item.data_low};
        n_cmd.row     = i_item.read_row;
        n_cmd.col     = i_item.read_col;
        if (i_item.func) begin
            n_cmd.op = cdg_pkg::OP_READ;
        end else if (i_item.command == cdg_pkg::CmdGraphics) begin
            n_cmd.refresh = 1'b1;
            n_cmd.handled = 1'b1;
            case (i_item.instruction)
                cdg_pkg::InstrPreset: begin
                    if (i_item.data_low[9:6] == 4'd0) begin
                        n_cmd.op = cdg_pkg::OP_FILL;
                    end
                end
                cdg_pkg::InstrBorder:  n_cmd.op = cdg_pkg::OP_BORDER;
                cdg_pkg::InstrTile:    n_cmd.op = cdg_pkg::OP_TILE;
                cdg_pkg::InstrXorTile: n_cmd.op = cdg_pkg::OP_XOR_TILE;
                cdg_pkg::InstrPalLow: begin
                    n_cmd.op      = cdg_pkg::OP_PALETTE;
                    n_cmd.pal_upd = 1'b1;
                    n_cmd.row     = 8'd0;
                end
                cdg_pkg::InstrPalHigh: begin
                    n_cmd.op      = cdg_pkg::OP_PALETTE;
                    n_cmd.pal_upd = 1'b1;
                    n_cmd.row     = 8'd8;
                end
                default: n_cmd.handled = 1'b0;
            endcase
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[sv/cdg_back.sv]
// Back end of the CD+G renderer: frame store, palette and the sequencer that
// carries out fills, tiles, palette loads and reads. Depends on cdg_pkg.
module cdg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  cdg_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output cdg_pkg::t_out_item o_item
);

    localparam int unsigned AW = cdg_pkg::AddrW;

    logic [3:0]  r_mem [cdg_pkg::FrameDepth];
    logic [11:0] r_pal [16];

    cdg_pkg::t_state r_state, n_state;
    cdg_pkg::t_cmd   r_cmd;
    logic [7:0]      r_row;
    logic [8:0]      r_col;
    logic [AW-1:0]   r_addr;
    logic [3:0]      r_rd;
    logic            r_fill_zero;
    logic [3:0]      r_fill_val;
    logic            r_out_valid;
    cdg_pkg::t_out_item r_out;

    logic            take, last_px, last_row, wr_en, rd_en, border;
    logic [3:0]      wr_data, c0, c1, tile_v;
    logic [8:0]      tile_r;
    logic [8:0]      tile_c;
    logic [5:0]      bits;
    logic [3:0]      ti;
    logic [2:0]      tj;
    logic [AW-1:0]   rd_addr;
    logic            on_screen;
    logic [3:0]      pal_idx;

    assign c0 = r_cmd.data[3:0];
    assign c1 = r_cmd.data[9:6];
    // Tile walk uses r_row/r_col as offsets within the 12x6 tile.
    assign ti     = r_row[3:0];
    assign tj     = r_col[2:0];
    // The tile row reaches 383, so it needs nine bits to be seen as off screen.
    assign tile_r = 9'(r_cmd.data[16:12] * 5'd12) + 9'(ti);
    assign tile_c = 9'(r_cmd.data[23:18] * 6'd6) + 9'(tj);
    assign bits   = r_cmd.data[6 * (32'(ti) + 4) +: 6];
    assign tile_v = bits[5 - tj] ? c1 : c0;
    assign on_screen = (tile_r < 9'(cdg_pkg::ScreenHeight)) &&
                       (tile_c < 9'(cdg_pkg::ScreenWidth));
    assign border = (r_row < cdg_pkg::BorderRows) || (r_row >= cdg_pkg::BorderRowEnd) ||
                    (r_col < cdg_pkg::BorderCols) || (r_col >= cdg_pkg::BorderColEnd);
    assign last_px  = (r_col == 9'(cdg_pkg::ScreenWidth - 1));
    assign last_row = (r_row == 8'(cdg_pkg::ScreenHeight - 1));
    assign pal_idx  = 4'(r_cmd.row) + 4'(r_row[2:0]);

    assign take        = (r_state == cdg_pkg::ST_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_cmd_ready = take;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdg_pkg::ST_CLEAR: begin
                if (r_addr == AW'(cdg_pkg::FrameDepth - 1)) n_state = cdg_pkg::ST_IDLE;
            end
            cdg_pkg::ST_IDLE: begin
                if (take) begin
                    case (i_cmd.op)
                        cdg_pkg::OP_READ:     n_state = cdg_pkg::ST_READ_WAIT;
                        cdg_pkg::OP_FILL,
                        cdg_pkg::OP_BORDER,
                        cdg_pkg::OP_PALETTE:  n_state = cdg_pkg::ST_SWEEP;
                        cdg_pkg::OP_TILE,
                        cdg_pkg::OP_XOR_TILE: n_state = cdg_pkg::ST_RMW_READ;
                        default:              n_state = cdg_pkg::ST_RESULT;
                    endcase
                end
            end
            cdg_pkg::ST_RMW_READ:  n_state = cdg_pkg::ST_RMW_WRITE;
            cdg_pkg::ST_RMW_WRITE: begin
                if (ti == 4'd11 && tj == 3'd5) n_state = cdg_pkg::ST_RESULT;
                else                           n_state = cdg_pkg::ST_RMW_READ;
            end
            cdg_pkg::ST_SWEEP: begin
                if (r_cmd.op == cdg_pkg::OP_PALETTE) begin
                    if (r_row[2:0] == 3'd7) n_state = cdg_pkg::ST_RESULT;
                end else if (last_px && last_row) begin
                    n_state = cdg_pkg::ST_RESULT;
                end
            end
            cdg_pkg::ST_READ_WAIT: n_state = cdg_pkg::ST_RESULT;
            cdg_pkg::ST_RESULT:    n_state = cdg_pkg::ST_IDLE;
            default:               n_state = cdg_pkg::ST_IDLE;
        endcase
    end

    // Frame store port controls.
    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_fill_val;
        rd_en   = 1'b0;
        rd_addr = r_addr;
        case (r_state)
            cdg_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = 4'd0;
            end
            cdg_pkg::ST_SWEEP: begin
                wr_en = (r_cmd.op == cdg_pkg::OP_FILL) ||
                        ((r_cmd.op == cdg_pkg::OP_BORDER) && border);
            end
            cdg_pkg::ST_RMW_READ: begin
                rd_en   = on_screen;
                rd_addr = AW'(tile_r * 9'(cdg_pkg::ScreenWidth)) + AW'(tile_c);
            end
            cdg_pkg::ST_RMW_WRITE: begin
                wr_en   = on_screen;
                wr_data = (r_cmd.op == cdg_pkg::OP_XOR_TILE) ? (r_rd ^ tile_v) : tile_v;
            end
            cdg_pkg::ST_IDLE: begin
                rd_en   = take && (i_cmd.op == cdg_pkg::OP_READ);
                rd_addr = AW'(i_cmd.row * 9'(cdg_pkg::ScreenWidth)) + AW'(i_cmd.col);
            end
            default: ;
        endcase
    end

    // Frame store memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Palette registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_pal[k] <= '0;
        end else if (r_state == cdg_pkg::ST_SWEEP && r_cmd.op == cdg_pkg::OP_PALETTE) begin
            r_pal[pal_idx] <= {r_cmd.data[12 * r_row[2:0] +: 6],
                               r_cmd.data[12 * r_row[2:0] + 6 +: 6]};
        end
    end

    // Sequencer state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdg_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                cdg_pkg::ST_CLEAR: r_addr <= r_addr + 1'b1;
                cdg_pkg::ST_IDLE: begin
                    r_addr <= '0;
                    r_row  <= '0;
                    r_col  <= '0;
                end
                cdg_pkg::ST_SWEEP: begin
                    if (r_cmd.op == cdg_pkg::OP_PALETTE) begin
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                        if (last_px) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                cdg_pkg::ST_RMW_READ: r_addr <= rd_addr;
                cdg_pkg::ST_RMW_WRITE: begin
                    if (tj == 3'd5) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                cdg_pkg::ST_RESULT: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Command capture and result formation.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd       <= i_cmd;
            r_fill_val  <= i_cmd.data[3:0];
            r_fill_zero <= (i_cmd.row >= 8'(cdg_pkg::ScreenHeight)) ||
                           (i_cmd.col >= 9'(cdg_pkg::ScreenWidth));
        end
        if (r_state == cdg_pkg::ST_RESULT) begin
            r_out.handled         <= r_cmd.handled;
            r_out.palette_updated <= r_cmd.pal_upd;
            r_out.refresh         <= r_cmd.refresh;
            if (r_cmd.op == cdg_pkg::OP_READ && !r_fill_zero) begin
                r_out.pixel_index <= r_rd;
                r_out.pixel_color <= r_pal[r_rd];
            end else begin
                r_out.pixel_index <= '0;
                r_out.pixel_color <= '0;
            end
        end
    end

endmodule

[sv/cd_graphics_packet_renderer_top.sv]
// Top level of the CD+G packet renderer: joins front end and back end.
// Depends on cdg_pkg, cdg_front and cdg_back.
//
// Usage: the input channel (i_valid/o_ready/i_item) takes one transaction per
// packet or pixel read; the output channel (o_valid/i_ready/o_item) returns
// exactly one result per transaction, in order.
// The front end classifies each transaction into a two-entry queue; the back
// end owns the single-port frame store and executes one command at a time.
// Work in the back end before o_valid, per kind of command:
//   ignored or unsupported packet : straight to the result state
//   pixel read                    : frame store read, then the result state
//   palette load                  : eight entry writes
//   tile or XOR tile              : read-modify-write of 72 pixels
//   memory or border preset       : one pixel per cycle sweep of the frame
// The frame store port sets how long each takes. The back end takes its next
// command only once the previous result has been accepted.
// After reset the back end clears the 64800-entry frame store, one entry a
// cycle, before it takes its first command; the front queue still fills.
// While the receiver stalls the result is held, the back end waits, and the
// queue fills up before o_ready falls.
module cd_graphics_packet_renderer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cdg_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output cdg_pkg::t_out_item  o_item
);

    logic          cmd_valid, cmd_ready;
    cdg_pkg::t_cmd cmd;

    cdg_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_cmd_valid (cmd_valid), .i_cmd_ready (cmd_ready), .o_cmd (cmd)
    );

    cdg_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid (cmd_valid), .o_cmd_ready (cmd_ready), .i_cmd (cmd),
        .o_valid, .i_ready, .o_item
    );

endmodule

[sv/cdg_checker.sv]
// Port-level checker for the CD+G packet renderer, bound to the top level.
// Depends on cdg_pkg.
module cdg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input cdg_pkg::t_out_item o_item
);

    // An offered transaction stays offered until taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("input transaction withdrawn while stalled");

    // A pending result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    // Palette update implies handled and refresh.
    a_pal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.palette_updated |-> o_item.handled && o_item.refresh)
        else $error("palette flag without graphics packet");

    // Handled implies refresh.
    a_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.handled |-> o_item.refresh)
        else $error("handled without refresh");

    // Graphics packets (refresh set) return no pixel index.
    a_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.refresh |-> o_item.pixel_index == 4'd0)
        else $error("packet result carries a pixel");

endmodule

bind cd_graphics_packet_renderer_top cdg_checker u_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_item
);

[tb/cd_graphics_packet_renderer_top_tb.sv]
// Self-checking testbench for cd_graphics_packet_renderer_top: packets and pixel reads
// are checked against a behavioural frame store and palette kept inside the bench.
// Depends on cdg_pkg and the renderer RTL.
`timescale 1ns / 100ps

module cd_graphics_packet_renderer_top_tb;

    localparam int unsigned RandomItems = 1130;
    localparam int unsigned CycleLimit  = 4000000;
    localparam int unsigned LongHold    = 3000;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    cdg_pkg::t_in_item  i_item  = '0;
    cdg_pkg::t_out_item o_item;

    // Behavioural copy of the renderer state.
    logic [3:0]  frame_model [cdg_pkg::FrameDepth];
    logic [11:0] pal_model [16];

    cdg_pkg::t_in_item  pending_items [$];
    bit                 drain_before [$];
    cdg_pkg::t_out_item expected_results [$];

    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_gap      = 0;
    int unsigned recv_stall    = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    bit          burst_mode    = 1'b0;

    cd_graphics_packet_renderer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [5:0] symbol(input cdg_pkg::t_in_item it, input int k);
        logic [95:0] d;
        d = {it.data_high, it.data_low};
        return d[6*k +: 6];
    endfunction

    function automatic void model_put(input int r, input int c, input logic [3:0] v,
                                      input bit xor_mode);
        int a;
        if (r >= cdg_pkg::ScreenHeight || c >= cdg_pkg::ScreenWidth) return;
        a = r * cdg_pkg::ScreenWidth + c;
        frame_model[a] = xor_mode ? (frame_model[a] ^ v) : v;
    endfunction

    // Applies one transaction to the model and returns the result it should give.
    function automatic cdg_pkg::t_out_item render_step(input cdg_pkg::t_in_item it);
        cdg_pkg::t_out_item res;
        logic [3:0]  c0, c1, v;
        logic [5:0]  bits;
        int          r0, k0, base;
        res = '0;
        if (it.func) begin
            if (it.read_row < cdg_pkg::ScreenHeight && it.read_col < cdg_pkg::ScreenWidth)
            begin
                res.pixel_index = frame_model[it.read_row * cdg_pkg::ScreenWidth +
                                              it.read_col];
                res.pixel_color = pal_model[res.pixel_index];
            end
        end else if (it.command == cdg_pkg::CmdGraphics) begin
            res.refresh = 1'b1;
            res.handled = 1'b1;
            c0 = 4'(symbol(it, 0));
            c1 = 4'(symbol(it, 1));
            case (it.instruction)
                cdg_pkg::InstrPreset: begin
                    if (c1 == 4'h0)
                        foreach (frame_model[a]) frame_model[a] = c0;
                end
                cdg_pkg::InstrBorder: begin
                    for (int r = 0; r < cdg_pkg::ScreenHeight; r++)
                        for (int c = 0; c < cdg_pkg::ScreenWidth; c++)
                            if (r < cdg_pkg::BorderRows || r >= cdg_pkg::BorderRowEnd ||
                                c < cdg_pkg::BorderCols || c >= cdg_pkg::BorderColEnd)
                                frame_model[r * cdg_pkg::ScreenWidth + c] = c0;
                end
                cdg_pkg::InstrTile, cdg_pkg::InstrXorTile: begin
                    r0 = int'(symbol(it, 2) & 6'h1F) * 12;
                    k0 = int'(symbol(it, 3)) * 6;
                    for (int i = 0; i < 12; i++) begin
                        bits = symbol(it, 4 + i);
                        for (int j = 0; j < 6; j++) begin
                            v = bits[5 - j] ? c1 : c0;
                            model_put(r0 + i, k0 + j, v,
                                      it.instruction == cdg_pkg::InstrXorTile);
                        end
                    end
                end
                cdg_pkg::InstrPalLow, cdg_pkg::InstrPalHigh: begin
                    base = (it.instruction == cdg_pkg::InstrPalHigh) ? 8 : 0;
                    for (int i = 0; i < 8; i++)
                        pal_model[base + i] = {symbol(it, 2 * i), symbol(it, 2 * i + 1)};
                    res.palette_updated = 1'b1;
                end
                default: res.handled = 1'b0;
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on result %0d: %s got 0x%0h, wanted 0x%0h",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic cdg_pkg::t_in_item mk_packet(input logic [5:0] cmd,
                                                    input logic [5:0] ins,
                                                    input logic [47:0] lo,
                                                    input logic [47:0] hi);
        cdg_pkg::t_in_item it;
        it = '0;
        it.command     = cmd;
        it.instruction = ins;
        it.data_low    = lo;
        it.data_high   = hi;
        // The read fields are ignored for packets, so they carry noise.
        it.read_row    = 8'($urandom);
        it.read_col    = 9'($urandom);
        return it;
    endfunction

    function automatic cdg_pkg::t_in_item mk_read(input int r, input int c);
        cdg_pkg::t_in_item it;
        it = '0;
        it.func        = 1'b1;
        it.command     = 6'($urandom);
        it.instruction = 6'($urandom);
        it.data_low    = rand48();
        it.data_high   = rand48();
        it.read_row    = 8'(r);
        it.read_col    = 9'(c);
        return it;
    endfunction

    // Tile data with the tile row in symbol 2 and tile column in symbol 3.
    function automatic logic [47:0] tile_low(input logic [3:0] c0, input logic [3:0] c1,
                                             input logic [5:0] trow, input logic [5:0] tcol);
        logic [47:0] lo;
        lo = rand48();
        lo[5:0]   = {2'($urandom_range(0, 3)), c0};
        lo[11:6]  = {2'($urandom_range(0, 3)), c1};
        lo[17:12] = trow;
        lo[23:18] = tcol;
        return lo;
    endfunction

    task automatic queue_item(input cdg_pkg::t_in_item it, input bit drain);
        pending_items.push_back(it);
        drain_before.push_back(drain);
    endtask

    // Sender: offers queued transactions with random gaps and occasional drains.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_results.push_back(render_step(i_item));
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             (!drain_before[0] ||
                              (expected_results.size() == 0 && !i_valid))) begin
                    i_item  <= pending_items.pop_front();
                    void'(drain_before.pop_front());
                    i_valid <= 1'b1;
                    if ($urandom_range(0, 40) == 0) burst_mode = !burst_mode;
                    send_gap <= burst_mode ? 0 : $urandom_range(0, 10);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and stalls at random, once for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    cdg_pkg::t_out_item want;
                    want = expected_results.pop_front();
                    if (o_item.pixel_index != want.pixel_index)
                        report_mismatch("pixel_index", int'(o_item.pixel_index),
                                        int'(want.pixel_index));
                    if (o_item.pixel_color != want.pixel_color)
                        report_mismatch("pixel_color", int'(o_item.pixel_color),
                                        int'(want.pixel_color));
                    if (o_item.handled != want.handled)
                        report_mismatch("handled", int'(o_item.handled),
                                        int'(want.handled));
                    if (o_item.palette_updated != want.palette_updated)
                        report_mismatch("palette_updated", int'(o_item.palette_updated),
                                        int'(want.palette_updated));
                    if (o_item.refresh != want.refresh)
                        report_mismatch("refresh", int'(o_item.refresh),
                                        int'(want.refresh));
                end
                results_seen++;
                recv_stall = burst_mode ? 0 : $urandom_range(0, 10);
                if (results_seen == 300 && !hold_done) begin
                    hold_left = LongHold;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus: a directed opening, then a random mix weighted towards tiles and reads.
    initial begin
        int unsigned       sel;
        int                last_r, last_c;
        logic [5:0]        trow, tcol, ins;
        cdg_pkg::t_in_item it;

        foreach (frame_model[a]) frame_model[a] = '0;
        foreach (pal_model[p]) pal_model[p] = '0;
        last_r = 0;
        last_c = 0;

        // Directed part.
        queue_item(mk_read(0, 0), 1'b0);
        queue_item(mk_read(216, 0), 1'b0);
        queue_item(mk_read(0, 300), 1'b0);
        queue_item(mk_read(255, 511), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, cdg_pkg::InstrPalLow, '1, '1), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, cdg_pkg::InstrPalHigh, rand48(),
                             rand48()), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, cdg_pkg::InstrPreset, 48'h5, rand48()),
                   1'b0);
        queue_item(mk_read(215, 299), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, cdg_pkg::InstrBorder, 48'hA, rand48()),
                   1'b0);
        queue_item(mk_read(12, 0), 1'b0);
        queue_item(mk_read(11, 150), 1'b0);
        queue_item(mk_read(204, 7), 1'b0);
        queue_item(mk_read(100, 294), 1'b0);
        queue_item(mk_read(100, 6), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, cdg_pkg::InstrTile,
                             tile_low(4'h0, 4'hF, 6'd0, 6'd0), '1), 1'b0);
        queue_item(mk_read(0, 0), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, cdg_pkg::InstrXorTile,
                             tile_low(4'hF, 4'h3, 6'h3F, 6'h3F), rand48()), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, cdg_pkg::InstrXorTile,
                             tile_low(4'h7, 4'h9, 6'd17, 6'd49), rand48()), 1'b0);
        queue_item(mk_read(215, 299), 1'b0);
        queue_item(mk_packet(6'h3F, cdg_pkg::InstrPreset, 48'h0, 48'h0), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, 6'd20, rand48(), rand48()), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, 6'd63, rand48(), rand48()), 1'b0);
        queue_item(mk_packet(cdg_pkg::CmdGraphics, cdg_pkg::InstrPreset, 48'h3C0,
                             rand48()), 1'b0);
        queue_item(mk_read(0, 0), 1'b0);

        // Random part; full-frame presets are rationed because each sweeps the frame.
        for (int n = 0; n < RandomItems; n++) begin
            sel = $urandom_range(0, 99);
            if (n % 300 == 150) begin
                it = mk_packet(cdg_pkg::CmdGraphics,
                               $urandom_range(0, 1) ? cdg_pkg::InstrPreset
                                                    : cdg_pkg::InstrBorder,
                               rand48(), rand48());
            end else if (sel < 35) begin
                if ($urandom_range(0, 3) == 0)
                    it = mk_read($urandom_range(0, 255), $urandom_range(0, 511));
                else if ($urandom_range(0, 1) == 0)
                    it = mk_read(last_r + $urandom_range(0, 11), last_c + $urandom_range(0, 5));
                else
                    it = mk_read($urandom_range(0, 215), $urandom_range(0, 299));
            end else if (sel < 72) begin
                trow = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(18, 63))
                                                   : 6'($urandom_range(0, 17));
                tcol = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(50, 63))
                                                   : 6'($urandom_range(0, 49));
                if (trow[4:0] < 18 && tcol < 50) begin
                    last_r = int'(trow[4:0]) * 12;
                    last_c = int'(tcol) * 6;
                end
                it = mk_packet(cdg_pkg::CmdGraphics,
                               $urandom_range(0, 1) ? cdg_pkg::InstrTile
                                                    : cdg_pkg::InstrXorTile,
                               tile_low(4'($urandom), 4'($urandom), trow, tcol), rand48());
            end else if (sel < 84) begin
                it = mk_packet(cdg_pkg::CmdGraphics,
                               $urandom_range(0, 1) ? cdg_pkg::InstrPalLow
                                                    : cdg_pkg::InstrPalHigh,
                               rand48(), rand48());
            end else if (sel < 92) begin
                do ins = 6'($urandom);
                while (ins == cdg_pkg::InstrPreset || ins == cdg_pkg::InstrBorder ||
                       ins == cdg_pkg::InstrTile || ins == cdg_pkg::InstrXorTile ||
                       ins == cdg_pkg::InstrPalLow || ins == cdg_pkg::InstrPalHigh);
                it = mk_packet(cdg_pkg::CmdGraphics, ins, rand48(), rand48());
            end else begin
                do ins = 6'($urandom);
                while (ins == cdg_pkg::CmdGraphics);
                it = mk_packet(ins, 6'($urandom), rand48(), rand48());
            end
            queue_item(it, n == 200 || n == 700);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/cdg_pkg.sv
sv/cdg_front.sv
sv/cdg_back.sv
sv/cd_graphics_packet_renderer_top.sv
sv/cdg_checker.sv
tb/cd_graphics_packet_renderer_top_tb.sv
